// ===== hw/rtl/bvm_pkg.sv =====
// package for the battery voltage monitor: widths, reset values, register indexes
package bvm_pkg;

    localparam int DEF_SAMPLES_PER_AVERAGE = 100;
    localparam int DEF_SAMPLE_BITS         = 12;

    localparam int GAIN_W   = 16;
    localparam int CELL_W   = 5;
    localparam int VOLT_W   = 13;
    localparam int PACK_W   = 17;
    localparam int DELAY_W  = 14;
    localparam int GAIN_SHR = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int OUT_FIELDS_W = VOLT_W + PACK_W + 4;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_CAL_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_ENTER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_STAY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_LEVEL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OVER_LEVEL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_DELAY   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_DELAY = 3'd7;

    localparam logic [GAIN_W-1:0]  RST_CAL_GAIN     = 16'd65535;
    localparam logic [CELL_W-1:0]  RST_CELL_COUNT   = 5'd1;
    localparam logic [VOLT_W-1:0]  RST_WARN_ENTER   = 13'd107;
    localparam logic [VOLT_W-1:0]  RST_WARN_STAY    = 13'd108;
    localparam logic [VOLT_W-1:0]  RST_CUTOFF_LEVEL = 13'd104;
    localparam logic [VOLT_W-1:0]  RST_OVER_LEVEL   = 13'd180;
    localparam logic [DELAY_W-1:0] RST_WARN_DELAY   = 14'd500;
    localparam logic [DELAY_W-1:0] RST_CUTOFF_DELAY = 14'd5000;

    localparam logic [VOLT_W-1:0]  DIODE_OFFSET = 13'd3;
    localparam logic [DELAY_W-1:0] RUN_MAX      = 14'd16383;

    typedef struct packed {
        logic [DELAY_W-1:0] count;
        logic               flag;
    } run_t;

endpackage

// ===== hw/rtl/battery_voltage_monitor.sv =====
// battery voltage monitor: block averaging, calibration and debounced low-voltage flags (also raised on over-voltage)
//
// usage:
//   s_ channel takes one item per ADC tick: tdata = {clear_low_latch, battery_sample}.
//   m_ channel returns exactly one item per input item, in order, carrying the held
//   per-battery and pack voltages, a flag for a completed average block and the
//   warning, cutoff and latched low-battery flags.
//   cfg_wr_en / cfg_wr_index / cfg_wr_data write one setup register per cycle;
//   write only while no item is in flight.
// timing:
//   four register stages (accumulate, reciprocal multiply for the mean, gain
//   multiply, voltage/flags with the output register): an item passes through them
//   in that order. one item per cycle is sustained while m_tready stays high.
//   every stage holds its own valid bit, so an empty stage fills while later ones stall.
// reset:
//   aresetn low clears the accumulator, held voltages, run counters and flags and
//   loads the register defaults. no item is in flight afterwards.
// stall:
//   when m_tready is low the result holds; earlier stages keep filling until the
//   pipeline is full, then s_tready drops.
module battery_voltage_monitor #(
    parameter int SAMPLES_PER_AVERAGE = bvm_pkg::DEF_SAMPLES_PER_AVERAGE,
    parameter int SAMPLE_BITS         = bvm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [SAMPLE_BITS-1:0] battery_sample, [SAMPLE_BITS] clear_low_latch, rest zero
    input  logic [((SAMPLE_BITS + 8) / 8) * 8-1:0] s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [12:0] battery_voltage, [29:13] pack_voltage, [30] average_updated,
    // [31] low_warning, [32] low_cutoff, [33] low_latched, rest zero
    output logic [bvm_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [bvm_pkg::CFG_IDX_W-1:0]        cfg_wr_index,
    input  logic [bvm_pkg::CFG_DATA_W-1:0]       cfg_wr_data
);
    import bvm_pkg::*;

    localparam int CNT_W    = $clog2(SAMPLES_PER_AVERAGE + 1);
    localparam int SUM_W    = SAMPLE_BITS + $clog2(SAMPLES_PER_AVERAGE);
    localparam int RECIP_SH = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SH) + 64'(SAMPLES_PER_AVERAGE) - 64'd1) / 64'(SAMPLES_PER_AVERAGE);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam int ADD_W = ((SAMPLE_BITS > VOLT_W) ? SAMPLE_BITS : VOLT_W) + 1;
    localparam logic [CNT_W-1:0] BLOCK_LEN = CNT_W'(SAMPLES_PER_AVERAGE);

    // setup registers
    logic [GAIN_W-1:0]  cal_gain_reg;
    logic [CELL_W-1:0]  cell_count_reg;
    logic [VOLT_W-1:0]  warn_enter_reg;
    logic [VOLT_W-1:0]  warn_stay_reg;
    logic [VOLT_W-1:0]  cutoff_level_reg;
    logic [VOLT_W-1:0]  over_level_reg;
    logic [DELAY_W-1:0] warn_delay_reg;
    logic [DELAY_W-1:0] cutoff_delay_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_gain_reg     <= RST_CAL_GAIN;
            cell_count_reg   <= RST_CELL_COUNT;
            warn_enter_reg   <= RST_WARN_ENTER;
            warn_stay_reg    <= RST_WARN_STAY;
            cutoff_level_reg <= RST_CUTOFF_LEVEL;
            over_level_reg   <= RST_OVER_LEVEL;
            warn_delay_reg   <= RST_WARN_DELAY;
            cutoff_delay_reg <= RST_CUTOFF_DELAY;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_CAL_GAIN:     cal_gain_reg     <= cfg_wr_data[GAIN_W-1:0];
                REG_CELL_COUNT:   cell_count_reg   <= cfg_wr_data[CELL_W-1:0];
                REG_WARN_ENTER:   warn_enter_reg   <= cfg_wr_data[VOLT_W-1:0];
                REG_WARN_STAY:    warn_stay_reg    <= cfg_wr_data[VOLT_W-1:0];
                REG_CUTOFF_LEVEL: cutoff_level_reg <= cfg_wr_data[VOLT_W-1:0];
                REG_OVER_LEVEL:   over_level_reg   <= cfg_wr_data[VOLT_W-1:0];
                REG_WARN_DELAY:   warn_delay_reg   <= cfg_wr_data[DELAY_W-1:0];
                REG_CUTOFF_DELAY: cutoff_delay_reg <= cfg_wr_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // stage handshakes
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, m_valid_reg;
    logic adv1, adv2, adv3, adv_out, in_accept;

    assign adv_out   = !m_valid_reg || m_tready;
    assign adv3      = !s3_valid_reg || adv_out;
    assign adv2      = !s2_valid_reg || adv3;
    assign adv1      = !s1_valid_reg || adv2;
    assign s_tready  = adv1;
    assign in_accept = s_tvalid && adv1;

    // stage 1: accumulate
    logic [SAMPLE_BITS-1:0] in_sample;
    logic                   in_clr;
    logic [CNT_W-1:0]       count_reg, count_inc;
    logic [SUM_W-1:0]       sum_reg, sum_inc;
    logic                   block_done;
    logic [SUM_W-1:0]       s1_sum_reg;
    logic                   s1_upd_reg, s1_clr_reg;

    assign in_sample  = s_tdata[SAMPLE_BITS-1:0];
    assign in_clr     = s_tdata[SAMPLE_BITS];
    assign count_inc  = count_reg + CNT_W'(1);
    assign sum_inc    = sum_reg + SUM_W'(in_sample);
    assign block_done = (count_inc == BLOCK_LEN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            sum_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (in_accept) begin
                count_reg <= block_done ? '0 : count_inc;
                sum_reg   <= block_done ? '0 : sum_inc;
            end
            if (adv1) begin
                s1_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_sum_reg <= sum_inc;
            s1_upd_reg <= block_done;
            s1_clr_reg <= in_clr;
        end
    end

    // stage 2: mean by reciprocal multiply
    logic [SUM_W+RECIP_W-1:0] recip_prod;
    logic [SAMPLE_BITS-1:0]   s2_mean_reg;
    logic                     s2_upd_reg, s2_clr_reg;

    assign recip_prod = (SUM_W+RECIP_W)'(s1_sum_reg) * (SUM_W+RECIP_W)'(RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2 && s1_valid_reg) begin
            s2_mean_reg <= recip_prod[RECIP_SH +: SAMPLE_BITS];
            s2_upd_reg  <= s1_upd_reg;
            s2_clr_reg  <= s1_clr_reg;
        end
    end

    // stage 3: calibration gain
    logic [SAMPLE_BITS+GAIN_W-1:0] gain_prod;
    logic [SAMPLE_BITS-1:0]        s3_hi_reg;
    logic                          s3_upd_reg, s3_clr_reg;

    assign gain_prod = (SAMPLE_BITS+GAIN_W)'(s2_mean_reg) * (SAMPLE_BITS+GAIN_W)'(cal_gain_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (adv3) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv3 && s2_valid_reg) begin
            s3_hi_reg  <= gain_prod[GAIN_SHR +: SAMPLE_BITS];
            s3_upd_reg <= s2_upd_reg;
            s3_clr_reg <= s2_clr_reg;
        end
    end

    // stage 4: held voltages, debounce, output register
    logic [VOLT_W-1:0]        held_volt_reg;
    logic [PACK_W-1:0]        held_pack_reg;
    logic [DELAY_W-1:0]       warn_cnt_reg, cut_cnt_reg;
    logic                     warn_on_reg, cut_on_reg, latched_reg, upd_reg;
    logic [ADD_W-1:0]         volt_sum;
    logic [VOLT_W-1:0]        volt_new, volt_next;
    logic [VOLT_W+CELL_W-1:0] pack_prod;
    logic                     over, warn_cond, cut_cond, out_load;
    run_t                     warn_next, cut_next;

    function automatic run_t run_step(input logic [DELAY_W-1:0] cnt,
                                      input logic cond,
                                      input logic [DELAY_W-1:0] delay);
        logic [DELAY_W-1:0] c;
        logic [DELAY_W:0]   sat;
        run_t               r;
        if (!cond) begin
            c = '0;
        end else if (cnt != RUN_MAX) begin
            c = cnt + DELAY_W'(1);
        end else begin
            c = cnt;
        end
        sat = {1'b0, delay} + (DELAY_W+1)'(2);
        if (c > delay) begin
            r.flag  = 1'b1;
            r.count = (sat > {1'b0, RUN_MAX}) ? RUN_MAX : sat[DELAY_W-1:0];
        end else begin
            r.flag  = 1'b0;
            r.count = c;
        end
        return r;
    endfunction

    assign volt_sum  = ADD_W'(s3_hi_reg) + ADD_W'(DIODE_OFFSET);
    assign volt_new  = volt_sum[VOLT_W-1:0];
    assign volt_next = s3_upd_reg ? volt_new : held_volt_reg;
    assign pack_prod = (VOLT_W+CELL_W)'(volt_new) * (VOLT_W+CELL_W)'(cell_count_reg);
    assign over      = volt_next > over_level_reg;
    assign warn_cond = (volt_next < (warn_on_reg ? warn_stay_reg : warn_enter_reg)) || over;
    assign cut_cond  = (volt_next < cutoff_level_reg) || over;
    assign warn_next = run_step(warn_cnt_reg, warn_cond, warn_delay_reg);
    assign cut_next  = run_step(cut_cnt_reg, cut_cond, cutoff_delay_reg);
    assign out_load  = adv_out && s3_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            held_volt_reg <= '0;
            held_pack_reg <= '0;
            warn_cnt_reg  <= '0;
            cut_cnt_reg   <= '0;
            warn_on_reg   <= 1'b0;
            cut_on_reg    <= 1'b0;
            latched_reg   <= 1'b0;
            upd_reg       <= 1'b0;
        end else begin
            if (adv_out) begin
                m_valid_reg <= s3_valid_reg;
            end
            if (out_load) begin
                if (s3_upd_reg) begin
                    held_volt_reg <= volt_new;
                    held_pack_reg <= pack_prod[PACK_W-1:0];
                end
                warn_cnt_reg <= warn_next.count;
                cut_cnt_reg  <= cut_next.count;
                warn_on_reg  <= warn_next.flag;
                cut_on_reg   <= cut_next.flag;
                latched_reg  <= (latched_reg && !s3_clr_reg) || cut_next.flag;
                upd_reg      <= s3_upd_reg;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({latched_reg, cut_on_reg, warn_on_reg, upd_reg,
                                    held_pack_reg, held_volt_reg});

    // a cutoff step always leaves the latch set
    assert property (@(posedge aclk) disable iff (!aresetn)
        cut_on_reg |-> latched_reg)
        else $error("cutoff flag without latched flag");

    // a pending updated result carries a pack voltage that matches the battery voltage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && upd_reg) |->
            (held_pack_reg == PACK_W'(held_volt_reg * (VOLT_W+CELL_W)'(cell_count_reg))))
        else $error("pack voltage out of step with battery voltage");

    // an item that completes a block reaches stage 1 flagged as an update
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (count_reg == BLOCK_LEN - CNT_W'(1))) |=> (s1_valid_reg && s1_upd_reg))
        else $error("block completion lost at accumulator");

endmodule
